/* src/psct_pkg.sv */
// ----------------------------------------------------------------------------
// psct_pkg
// Shared constants, codes and controller/datapath interface types for the
// prime sieve count table block.
// ----------------------------------------------------------------------------
package psct_pkg;

	// default table depth and fixed field widths
	localparam int unsigned TABLE_SIZE_DEF = 65536;
	localparam int unsigned VALUE_W        = 16;
	localparam int unsigned COUNT_W        = 13;
	localparam int unsigned IN_TDATA_W     = 32;
	localparam int unsigned OUT_TDATA_W    = 16;

	// request operation codes (s_axis_tuser)
	localparam logic OP_BUILD = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// result kind codes (m_axis_tuser)
	localparam logic KIND_BUILD = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// controller to datapath commands
	typedef struct packed {
		logic init_start;   // clear index before flag fill
		logic init_step;    // write one prime flag, advance index
		logic sieve_start;  // base prime 2, square 4
		logic sieve_rd;     // read flag of current base
		logic mark_start;   // index to square of base
		logic mark_step;    // clear one multiple, advance by base
		logic sieve_next;   // next base and its square
		logic cnt_start;    // clear index and running count
		logic cnt_step;     // read one flag for the count pass
		logic query_rd;     // read count table at request value
		logic out_load;     // load the output register
		logic out_kind;     // kind of the loaded result
	} psct_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic idx_last;     // index at last table entry
		logic idx_ge_n;     // marking index past the table
		logic sieve_done;   // square of base reached table size
		logic flag;         // flag read data
		logic out_free;     // output register can take a result
	} psct_sts_t;

endpackage

/* src/psct_ram.sv */
// ----------------------------------------------------------------------------
// psct_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module psct_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read, holds when not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* src/psct_dp.sv */
// ----------------------------------------------------------------------------
// psct_dp
// Datapath: flag and count memories, sieve counters, count pipeline and the
// output register.
// ----------------------------------------------------------------------------
module psct_dp #(
	parameter int unsigned TABLE_SIZE = psct_pkg::TABLE_SIZE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  psct_pkg::psct_cmd_t           cmd,
	output psct_pkg::psct_sts_t           sts,
	input  logic [psct_pkg::VALUE_W-1:0]  query_value,
	input  logic [psct_pkg::VALUE_W-1:0]  count_bound,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic                          out_kind,
	output logic [psct_pkg::COUNT_W-1:0]  out_count,
	output logic                          out_within
);
	import psct_pkg::*;

	localparam int unsigned AW = $clog2(TABLE_SIZE);
	localparam int unsigned IW = AW + 1;

	logic [IW-1:0]      idx_q;
	logic [IW-1:0]      p_q;
	logic [IW-1:0]      sq_q;
	logic [COUNT_W-1:0] cnt_q;
	logic               cnt_vld_s1;
	logic [AW-1:0]      cnt_idx_s1;
	logic [VALUE_W-1:0] bound_q;
	logic               out_valid_q;
	logic               out_kind_q;
	logic [COUNT_W-1:0] out_count_q;
	logic               out_within_q;

	logic               flag_wr_en;
	logic               flag_wr_data;
	logic               flag_rd_en;
	logic [AW-1:0]      flag_rd_addr;
	logic               flag_rd;
	logic [COUNT_W-1:0] cnt_next;
	logic [AW-1:0]      query_addr;
	logic [COUNT_W-1:0] count_rd;

	// flag memory port control
	assign flag_wr_en   = cmd.init_step | cmd.mark_step;
	assign flag_wr_data = cmd.init_step ? (idx_q >= IW'(2)) : 1'b0;
	assign flag_rd_en   = cmd.sieve_rd | cmd.cnt_step;
	assign flag_rd_addr = cmd.sieve_rd ? p_q[AW-1:0] : idx_q[AW-1:0];

	psct_ram #(
		.WIDTH (1),
		.DEPTH (TABLE_SIZE)
	) u_flag_ram (
		.clk     (clk),
		.wr_en   (flag_wr_en),
		.wr_addr (idx_q[AW-1:0]),
		.wr_data (flag_wr_data),
		.rd_en   (flag_rd_en),
		.rd_addr (flag_rd_addr),
		.rd_data (flag_rd)
	);

	// running count for the entry leaving the read stage
	assign cnt_next = cnt_q + COUNT_W'(flag_rd);

	// saturate query value to the last table entry
	always_comb begin
		if (32'(query_value) >= 32'(TABLE_SIZE)) begin
			query_addr = AW'(TABLE_SIZE - 1);
		end else begin
			query_addr = AW'(query_value);
		end
	end

	psct_ram #(
		.WIDTH (COUNT_W),
		.DEPTH (TABLE_SIZE)
	) u_count_ram (
		.clk     (clk),
		.wr_en   (cnt_vld_s1),
		.wr_addr (cnt_idx_s1),
		.wr_data (cnt_next),
		.rd_en   (cmd.query_rd),
		.rd_addr (query_addr),
		.rd_data (count_rd)
	);

	// sweep index: fill, marking and count pass
	always_ff @(posedge clk) begin
		if (cmd.init_start || cmd.cnt_start) begin
			idx_q <= '0;
		end else if (cmd.mark_start) begin
			idx_q <= sq_q;
		end else if (cmd.mark_step) begin
			idx_q <= idx_q + p_q;
		end else if (cmd.init_step || cmd.cnt_step) begin
			idx_q <= idx_q + IW'(1);
		end
	end

	// base prime and its square, square advanced incrementally
	always_ff @(posedge clk) begin
		if (cmd.sieve_start) begin
			p_q  <= IW'(2);
			sq_q <= IW'(4);
		end else if (cmd.sieve_next) begin
			p_q  <= p_q + IW'(1);
			sq_q <= sq_q + (p_q << 1) + IW'(1);
		end
	end

	// count pass pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_s1 <= 1'b0;
		end else begin
			cnt_vld_s1 <= cmd.cnt_step;
		end
	end

	always_ff @(posedge clk) begin
		cnt_idx_s1 <= idx_q[AW-1:0];
		if (cmd.cnt_start) begin
			cnt_q <= '0;
		end else if (cnt_vld_s1) begin
			cnt_q <= cnt_next;
		end
		if (cmd.query_rd) begin
			bound_q <= count_bound;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_kind_q <= cmd.out_kind;
			if (cmd.out_kind == KIND_QUERY) begin
				out_count_q  <= count_rd;
				out_within_q <= VALUE_W'(count_rd) <= bound_q;
			end else begin
				out_count_q  <= '0;
				out_within_q <= 1'b0;
			end
		end
	end

	// status
	assign sts.idx_last   = (idx_q == IW'(TABLE_SIZE - 1));
	assign sts.idx_ge_n   = (idx_q >= IW'(TABLE_SIZE));
	assign sts.sieve_done = (sq_q >= IW'(TABLE_SIZE));
	assign sts.flag       = flag_rd;
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign out_kind   = out_kind_q;
	assign out_count  = out_count_q;
	assign out_within = out_within_q;

endmodule

/* src/psct_ctrl.sv */
// ----------------------------------------------------------------------------
// psct_ctrl
// Controller: sequences the build (flag fill, sieve, count pass) and the
// query read, and hands results to the output register.
// ----------------------------------------------------------------------------
module psct_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_op,
	output logic                req_ready,
	output psct_pkg::psct_cmd_t cmd,
	input  psct_pkg::psct_sts_t sts
);
	import psct_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_SV_TEST,
		ST_SV_WAIT,
		ST_MARK,
		ST_CNT,
		ST_CNT_DRAIN,
		ST_RESP
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   kind_q;
	logic   kind_nxt;

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		kind_nxt  = kind_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (req_op == OP_BUILD) begin
						cmd.init_start = 1'b1;
						kind_nxt       = KIND_BUILD;
						state_nxt      = ST_INIT;
					end else begin
						cmd.query_rd = 1'b1;
						kind_nxt     = KIND_QUERY;
						state_nxt    = ST_RESP;
					end
				end
			end
			ST_INIT: begin
				cmd.init_step = 1'b1;
				if (sts.idx_last) begin
					cmd.sieve_start = 1'b1;
					state_nxt       = ST_SV_TEST;
				end
			end
			ST_SV_TEST: begin
				if (sts.sieve_done) begin
					cmd.cnt_start = 1'b1;
					state_nxt     = ST_CNT;
				end else begin
					cmd.sieve_rd = 1'b1;
					state_nxt    = ST_SV_WAIT;
				end
			end
			ST_SV_WAIT: begin
				if (sts.flag) begin
					cmd.mark_start = 1'b1;
					state_nxt      = ST_MARK;
				end else begin
					cmd.sieve_next = 1'b1;
					state_nxt      = ST_SV_TEST;
				end
			end
			ST_MARK: begin
				if (sts.idx_ge_n) begin
					cmd.sieve_next = 1'b1;
					state_nxt      = ST_SV_TEST;
				end else begin
					cmd.mark_step = 1'b1;
				end
			end
			ST_CNT: begin
				cmd.cnt_step = 1'b1;
				if (sts.idx_last) begin
					state_nxt = ST_CNT_DRAIN;
				end
			end
			ST_CNT_DRAIN: begin
				state_nxt = ST_RESP;
			end
			ST_RESP: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = kind_q;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= KIND_BUILD;
		end else begin
			state_q <= state_nxt;
			kind_q  <= kind_nxt;
		end
	end

	assign req_ready = (state_q == ST_IDLE);

endmodule

/* src/prime_sieve_count_table_core.sv */
// ----------------------------------------------------------------------------
// prime_sieve_count_table_core
// Prime counting table built by a sieve, answering prime count queries.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries requests: tuser selects build (0) or query (1), tdata
//   holds query_value and count_bound. m_axis returns one result per
//   request: tuser gives the kind, tdata the prime count and bound flag.
//   A build must precede the first query after reset.
// Operation:
//   A query reads the count memory, then compares into the output register;
//   a new request is taken only after the result is loaded.
//   A build fills the flag memory with one flag write per cycle, then runs
//   the sieve with one multiple cleared per cycle for each base prime below
//   sqrt(TABLE_SIZE), then writes one count entry per cycle; the single flag
//   memory write port sets the fill and marking rate.
// Reset:
//   Clears the controller and output valid; memory contents are undefined
//   until the first build.
// Stall:
//   A result waits in the output register while m_axis_tready is low; the
//   next request is still accepted and its result waits until the register
//   frees.
// ----------------------------------------------------------------------------
module prime_sieve_count_table_core #(
	parameter int unsigned TABLE_SIZE = psct_pkg::TABLE_SIZE_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [15:0] query_value, [31:16] count_bound
	input  logic [psct_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// [0] operation
	input  logic                             s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [12:0] prime_count, [13] within_bound, [15:14] zero
	output logic [psct_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// [0] result_kind
	output logic                             m_axis_tuser
);
	import psct_pkg::*;

	psct_cmd_t          cmd;
	psct_sts_t          sts;
	logic [COUNT_W-1:0] out_count;
	logic               out_within;

	psct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req_op    (s_axis_tuser),
		.req_ready (s_axis_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	psct_dp #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.query_value (s_axis_tdata[VALUE_W-1:0]),
		.count_bound (s_axis_tdata[2*VALUE_W-1:VALUE_W]),
		.out_ready   (m_axis_tready),
		.out_valid   (m_axis_tvalid),
		.out_kind    (m_axis_tuser),
		.out_count   (out_count),
		.out_within  (out_within)
	);

	// pack result fields, lowest first
	assign m_axis_tdata = {(OUT_TDATA_W - COUNT_W - 1)'(0), out_within, out_count};

endmodule

/* src/psct_checker.sv */
// ----------------------------------------------------------------------------
// psct_checker
// Port-level checks for the prime sieve count table block, bound to the
// top level.
// ----------------------------------------------------------------------------
module psct_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic [psct_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input logic                             s_axis_tuser,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [psct_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                             m_axis_tuser
);
	import psct_pkg::*;

	// one request in flight: busy in the cycle after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted while previous one in flight");

	// query with a free output answers after the count read and output load
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_QUERY) &&
		(!m_axis_tvalid || m_axis_tready) |-> ##2 m_axis_tvalid)
		else $error("query result late");

	// build acknowledgement carries no count
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == KIND_BUILD) |-> (m_axis_tdata == '0))
		else $error("build result with nonzero data");

	// a zero count is always within bound
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == KIND_QUERY) &&
		(m_axis_tdata[COUNT_W-1:0] == '0) |-> m_axis_tdata[COUNT_W])
		else $error("zero count reported out of bound");

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

endmodule

bind prime_sieve_count_table_core psct_checker u_psct_checker (.*);

/* tb/sv/prime_sieve_count_table_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// prime_sieve_count_table_core_tb
// Self-checking bench for the prime sieve count table core. A queue of
// requests feeds a clocked stream driver. Every accepted request is run
// through a local sieve and prime count predictor. A clocked monitor checks
// each returned result against the oldest predicted answer. Stimulus starts
// with directed build and edge queries. Three phases of shaped random queries
// follow, with random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module prime_sieve_count_table_core_tb;
	import psct_pkg::*;

	localparam int unsigned TBL_N      = TABLE_SIZE_DEF;
	localparam int unsigned TBL_AW     = $clog2(TBL_N);
	localparam int unsigned PHASE_REQS = 443;
	localparam int unsigned HOLD_LEN   = 400;
	localparam int unsigned MAX_PRINTS = 40;

	typedef struct {
		logic               op;
		logic [VALUE_W-1:0] value;
		logic [VALUE_W-1:0] bound;
	} request_t;

	typedef struct {
		logic               kind;
		logic [COUNT_W-1:0] count;
		logic               in_bound;
	} answer_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   s_axis_tuser = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;

	// predictor state: sieve marks and running prime counts
	bit                     composite [TBL_N];
	logic [COUNT_W-1:0]     prime_count_tab [TBL_N];

	request_t               pending_requests [$];
	answer_t                pending_answers [$];
	request_t               offered_req;
	answer_t                oldest_answer;

	int unsigned            send_idle_pct = 26;
	int unsigned            recv_idle_pct = 66;
	bit                     hold_armed = 1'b0;
	bit                     hold_done = 1'b0;
	int unsigned            hold_left = 0;
	int unsigned            n_builds = 0;
	int unsigned            n_queries = 0;
	int unsigned            n_checked = 0;
	int unsigned            n_within = 0;
	int unsigned            n_over = 0;
	int unsigned            n_errors = 0;

	prime_sieve_count_table_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	// sieve on build, table lookup and bound compare on query
	function automatic answer_t predict_answer(request_t req);
		answer_t     ans;
		int unsigned p, m, idx, run;
		if (req.op == OP_BUILD) begin
			foreach (composite[i]) composite[i] = 1'b0;
			composite[0] = 1'b1;
			composite[1] = 1'b1;
			for (p = 2; p * p < TBL_N; p++)
				if (!composite[p[TBL_AW-1:0]])
					for (m = p * p; m < TBL_N; m += p) composite[m[TBL_AW-1:0]] = 1'b1;
			run = 0;
			for (idx = 0; idx < TBL_N; idx++) begin
				if (!composite[idx[TBL_AW-1:0]]) run++;
				prime_count_tab[idx[TBL_AW-1:0]] = run[COUNT_W-1:0];
			end
			ans.kind     = KIND_BUILD;
			ans.count    = '0;
			ans.in_bound = 1'b0;
		end else begin
			idx = 32'(req.value);
			// values past the table read its last entry
			if (idx >= TBL_N) idx = TBL_N - 1;
			ans.kind     = KIND_QUERY;
			ans.count    = prime_count_tab[idx[TBL_AW-1:0]];
			ans.in_bound = (prime_count_tab[idx[TBL_AW-1:0]] <= req.bound);
		end
		return ans;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		if (n_errors < MAX_PRINTS)
			$display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
		n_errors++;
	endtask

	task automatic queue_request(logic op, int unsigned value, int unsigned bound);
		request_t req;
		req.op    = op;
		req.value = value[VALUE_W-1:0];
		req.bound = bound[VALUE_W-1:0];
		pending_requests.insert(pending_requests.size(), req);
	endtask

	// random queries, biased toward small values, the table top and tight bounds
	task automatic queue_random_queries(int unsigned n);
		request_t    req;
		int unsigned sel, c;
		repeat (n) begin
			req.op = OP_QUERY;
			sel = $urandom_range(7);
			if (sel < 2)
				req.value = VALUE_W'($urandom_range(300));
			else if (sel == 2)
				req.value = VALUE_W'($urandom_range(65535, 65000));
			else
				req.value = VALUE_W'($urandom);
			c = 32'(prime_count_tab[req.value]);
			sel = $urandom_range(3);
			if (sel == 0)
				req.bound = VALUE_W'($urandom);
			else if (sel == 1)
				req.bound = VALUE_W'($urandom_range(7000));
			else if (c < 3)
				req.bound = VALUE_W'($urandom_range(c + 3));
			else
				req.bound = VALUE_W'(c - 3 + $urandom_range(6));
			pending_requests.insert(pending_requests.size(), req);
		end
	endtask

	// wait until every request went in and every answer came back
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_requests.size() != 0 || s_axis_tvalid || pending_answers.size() != 0);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				pending_answers.insert(pending_answers.size(), predict_answer(offered_req));
				if (offered_req.op == OP_BUILD) n_builds++;
				else n_queries++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					offered_req = pending_requests.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {offered_req.bound, offered_req.value};
					s_axis_tuser  <= offered_req.op;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// long output hold-off, started once in the last phase
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_armed && !hold_done) begin
			hold_left <= HOLD_LEN;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// result monitor and output ready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_answers.size() == 0) begin
					report_mismatch("result with no request pending", 32'(m_axis_tdata), 0);
				end else begin
					oldest_answer = pending_answers.pop_front();
					if (m_axis_tuser !== oldest_answer.kind)
						report_mismatch("result_kind", 32'(m_axis_tuser),
							32'(oldest_answer.kind));
					if (m_axis_tdata[COUNT_W-1:0] !== oldest_answer.count)
						report_mismatch("prime_count", 32'(m_axis_tdata[COUNT_W-1:0]),
							32'(oldest_answer.count));
					if (m_axis_tdata[COUNT_W] !== oldest_answer.in_bound)
						report_mismatch("within_bound", 32'(m_axis_tdata[COUNT_W]),
							32'(oldest_answer.in_bound));
					if (m_axis_tdata[OUT_TDATA_W-1:COUNT_W+1] !== '0)
						report_mismatch("tdata padding",
							32'(m_axis_tdata[OUT_TDATA_W-1:COUNT_W+1]), 0);
					n_checked++;
					if (oldest_answer.kind == KIND_QUERY) begin
						if (oldest_answer.in_bound) n_within++;
						else n_over++;
					end
				end
			end
			m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// stimulus and end of run
	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// build first, then edge values and bounds right at the count
		queue_request(OP_BUILD, 0, 0);
		queue_request(OP_QUERY, 0, 0);
		queue_request(OP_QUERY, 1, 0);
		queue_request(OP_QUERY, 2, 0);
		queue_request(OP_QUERY, 2, 1);
		queue_request(OP_QUERY, 3, 65535);
		queue_request(OP_QUERY, 4, 2);
		queue_request(OP_QUERY, 100, 25);
		queue_request(OP_QUERY, 100, 24);
		queue_request(OP_QUERY, 1000, 168);
		queue_request(OP_QUERY, 65520, 6542);
		queue_request(OP_QUERY, 65521, 6541);
		queue_request(OP_QUERY, 65534, 6542);
		queue_request(OP_QUERY, 65535, 6542);
		queue_request(OP_QUERY, 65535, 6541);
		queue_request(OP_QUERY, 65535, 65535);
		queue_request(OP_QUERY, 16'hAAAA, 16'h5555);
		queue_request(OP_QUERY, 16'h5555, 16'hAAAA);
		// a second build rebuilds the same table
		queue_request(OP_BUILD, 65535, 65535);
		queue_request(OP_QUERY, 65535, 6542);
		queue_request(OP_QUERY, 2, 1);
		queue_request(OP_QUERY, 0, 65535);
		wait_idle();

		queue_random_queries(PHASE_REQS);
		wait_idle();

		send_idle_pct = 66;
		recv_idle_pct = 26;
		queue_random_queries(PHASE_REQS);
		wait_idle();

		// no idling, and the output side stalls long enough to back up the input
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_armed = 1'b1;
		queue_random_queries(PHASE_REQS);
		wait_idle();
		repeat (20) @(negedge clk);

		$display("covered %0d builds and %0d queries, %0d results checked",
			n_builds, n_queries, n_checked);
		$display("queries within bound %0d, over bound %0d, one %0d cycle output stall",
			n_within, n_over, HOLD_LEN);
		if (n_errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// two full builds dominate the run; this leaves ample margin
	initial begin
		#30ms;
		$display("timeout with %0d answers outstanding", pending_answers.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
